FILE: hdl/adh_pkg.sv
`timescale 1ns / 1ps
// adh_pkg: shared constants and types of the access distance histogram
// no dependencies

package adh_pkg;

	// fixed field widths
	localparam int TAG_W     = 64;
	localparam int OFF_W     = 4;
	localparam int BIN_IDX_W = 10;
	localparam int DIST_W    = 10;
	localparam int BIN_W     = 32;
	localparam int REUSE_W   = 40;

	// tags compared per cycle, one tag memory bank per lane
	localparam int LANES   = 16;
	localparam int LANE_AW = $clog2(LANES);

	// parameter defaults
	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int HIST_BINS_DEF     = 1024;
	localparam int COUNT_WIDTH_DEF   = 40;

	localparam logic [OFF_W-1:0] OFFSET_RESET = 4'd6;

	// result of comparing one row of tags
	typedef struct packed {
		logic               hit;
		logic [LANE_AW-1:0] lane;
	} match_t;

endpackage

FILE: hdl/adh_ram.sv
`timescale 1ns / 1ps
// adh_ram: generic simple dual port ram with registered read
// no dependencies

module adh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/adh_match.sv
`timescale 1ns / 1ps
// adh_match: compares one row of stored tags against the search tag
// depends on adh_pkg

module adh_match
	import adh_pkg::*;
(
	input  logic [LANES-1:0][TAG_W-1:0] row_tags,
	input  logic [LANES-1:0]            lane_valid,
	input  logic [TAG_W-1:0]            tag,
	output match_t                      result
);

	logic [LANES-1:0] eq;

	// per lane compare, lowest matching lane wins
	always_comb begin
		result = '0;
		for (int l = 0; l < LANES; l++) begin
			eq[l] = lane_valid[l] && (row_tags[l] == tag);
		end
		for (int l = LANES - 1; l >= 0; l--) begin
			if (eq[l]) begin
				result.hit  = 1'b1;
				result.lane = LANE_AW'(l);
			end
		end
	end

endmodule

FILE: hdl/access_distance_histogram.sv
`timescale 1ns / 1ps
// access_distance_histogram: top level of the reuse distance profiler
// depends on adh_pkg, adh_ram, adh_match

// After reset the histogram memory is cleared with busy high. An access
// transaction searches the tracked blocks 16 tags per cycle from banked tag
// memory, one row of 16 entries at a time, up to the row that hits, or through
// every row holding used entries on a miss (no search when the table is
// empty), then passes through ST_HIT_RD and ST_HIT_UP on a hit or ST_MISS on
// a miss before busy falls. A read transaction keeps busy high for one cycle.
// The result appears with done high for one cycle, the first cycle with busy
// low, and is never held back, so the receiver must take it then; a new start
// may be given in that same cycle.

module access_distance_histogram
	import adh_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int HIST_BINS     = HIST_BINS_DEF,
	parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [OFF_W-1:0]     cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic [TAG_W-1:0]     address,
	input  logic [BIN_IDX_W-1:0] bin_index,
	output logic                 done,
	output logic                 reused,
	output logic [DIST_W-1:0]    distance,
	output logic                 dropped,
	output logic [BIN_W-1:0]     bin_count,
	output logic [REUSE_W-1:0]   reuse_total
);

	localparam int ROWS   = TABLE_ENTRIES / LANES;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ENT_AW = $clog2(TABLE_ENTRIES);
	localparam int EU_W   = $clog2(TABLE_ENTRIES + 1);
	localparam int HB_AW  = $clog2(HIST_BINS);

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SEARCH = 3'd2;
	localparam logic [2:0] ST_HIT_RD = 3'd3;
	localparam logic [2:0] ST_HIT_UP = 3'd4;
	localparam logic [2:0] ST_MISS   = 3'd5;
	localparam logic [2:0] ST_READ   = 3'd6;

	localparam logic [HB_AW-1:0]       LAST_BIN = HB_AW'(HIST_BINS - 1);
	localparam logic [COUNT_WIDTH-1:0] LAST_BIN_C = COUNT_WIDTH'(HIST_BINS - 1);
	localparam logic [COUNT_WIDTH-1:0] DIST_MAX_C = COUNT_WIDTH'((1 << DIST_W) - 1);
	localparam logic [EU_W-1:0]        FULL_EU = EU_W'(TABLE_ENTRIES);

	logic [2:0]             state_q;
	logic [OFF_W-1:0]       offset_q;
	logic [COUNT_WIDTH-1:0] acc_q;
	logic [EU_W-1:0]        eu_q;
	logic [REUSE_W-1:0]     reuse_q;
	logic [TAG_W-1:0]       blk_q;
	logic [ROW_AW-1:0]      row_q;
	logic [ENT_AW-1:0]      hit_idx_q;
	logic [HB_AW-1:0]       hb_q;
	logic [DIST_W-1:0]      dist_q;
	logic                   bin_ok_q;
	logic [HB_AW-1:0]       clr_q;

	logic [LANES-1:0][TAG_W-1:0] row_tags;
	logic [LANES-1:0]            lane_valid;
	logic [LANES-1:0]            tag_we;
	match_t                      match;
	logic [ROW_AW-1:0]           tag_raddr;
	logic [ROW_AW-1:0]           eu_row;
	logic [ROW_AW-1:0]           last_row;
	logic [ENT_AW-1:0]           hit_idx;

	logic                   ls_we;
	logic [ENT_AW-1:0]      ls_waddr;
	logic [ENT_AW-1:0]      ls_raddr;
	logic [COUNT_WIDTH-1:0] ls_rdata;
	logic [COUNT_WIDTH-1:0] span;
	logic [HB_AW-1:0]       hb;

	logic                   h_we;
	logic [HB_AW-1:0]       h_waddr;
	logic [BIN_W-1:0]       h_wdata;
	logic [HB_AW-1:0]       h_raddr;
	logic [BIN_W-1:0]       h_rdata;

	assign busy = (state_q != ST_IDLE);

	// search row bookkeeping
	assign tag_raddr = (state_q == ST_SEARCH) ? row_q + 1'b1 : '0;
	assign eu_row    = ROW_AW'(eu_q >> LANE_AW);
	assign last_row  = ROW_AW'((eu_q - 1'b1) >> LANE_AW);
	assign hit_idx   = ENT_AW'({row_q, match.lane});

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lane_valid[l] = EU_W'({row_q, LANE_AW'(l)}) < eu_q;
			tag_we[l] = (state_q == ST_MISS) && (eu_q != FULL_EU)
				&& (eu_q[LANE_AW-1:0] == LANE_AW'(l));
		end
	end

	// tag memory, one bank per lane
	for (genvar l = 0; l < LANES; l++) begin : g_tag
		adh_ram #(.WIDTH(TAG_W), .DEPTH(ROWS), .AW(ROW_AW)) u_tag (
			.clk   (clk),
			.we    (tag_we[l]),
			.waddr (eu_row),
			.wdata (blk_q),
			.raddr (tag_raddr),
			.rdata (row_tags[l])
		);
	end

	adh_match u_match (
		.row_tags   (row_tags),
		.lane_valid (lane_valid),
		.tag        (blk_q),
		.result     (match)
	);

	// last seen count memory
	always_comb begin
		ls_we    = 1'b0;
		ls_waddr = hit_idx_q;
		if (state_q == ST_HIT_RD) begin
			ls_we = 1'b1;
		end else if (state_q == ST_MISS && eu_q != FULL_EU) begin
			ls_we    = 1'b1;
			ls_waddr = ENT_AW'(eu_q);
		end
	end
	assign ls_raddr = hit_idx;

	adh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TABLE_ENTRIES), .AW(ENT_AW)) u_last (
		.clk   (clk),
		.we    (ls_we),
		.waddr (ls_waddr),
		.wdata (acc_q),
		.raddr (ls_raddr),
		.rdata (ls_rdata)
	);

	// distance and its histogram bin
	assign span = acc_q - ls_rdata;
	assign hb   = (span >= LAST_BIN_C) ? LAST_BIN : HB_AW'(span);

	// histogram memory: clearing pass, saturating increment
	always_comb begin
		h_we    = 1'b0;
		h_waddr = hb_q;
		h_wdata = (h_rdata == '1) ? h_rdata : h_rdata + 1'b1;
		h_raddr = (state_q == ST_HIT_RD) ? hb : HB_AW'(bin_index);
		if (state_q == ST_CLR) begin
			h_we    = 1'b1;
			h_waddr = clr_q;
			h_wdata = '0;
		end else if (state_q == ST_HIT_UP) begin
			h_we = 1'b1;
		end
	end

	adh_ram #(.WIDTH(BIN_W), .DEPTH(HIST_BINS), .AW(HB_AW)) u_hist (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			blk_q    <= address >> offset_q;
			bin_ok_q <= 32'(bin_index) < HIST_BINS;
		end
		if (state_q == ST_SEARCH) begin
			hit_idx_q <= hit_idx;
		end
		if (state_q == ST_HIT_RD) begin
			hb_q   <= hb;
			dist_q <= (span >= DIST_MAX_C) ? DIST_W'(DIST_MAX_C) : DIST_W'(span);
		end
	end

	// control state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			offset_q    <= OFFSET_RESET;
			acc_q       <= '0;
			eu_q        <= '0;
			reuse_q     <= '0;
			row_q       <= '0;
			clr_q       <= '0;
			done        <= 1'b0;
			reused      <= 1'b0;
			distance    <= '0;
			dropped     <= 1'b0;
			bin_count   <= '0;
			reuse_total <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				offset_q <= cfg_data;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_BIN) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					row_q <= '0;
					if (start) begin
						if (req_type) begin
							state_q <= ST_READ;
						end else begin
							acc_q   <= acc_q + 1'b1;
							state_q <= (eu_q == '0) ? ST_MISS : ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (match.hit) begin
						state_q <= ST_HIT_RD;
					end else if (row_q == last_row) begin
						state_q <= ST_MISS;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				ST_HIT_RD: begin
					state_q <= ST_HIT_UP;
				end
				ST_HIT_UP: begin
					if (reuse_q != '1) begin
						reuse_q     <= reuse_q + 1'b1;
						reuse_total <= reuse_q + 1'b1;
					end else begin
						reuse_total <= reuse_q;
					end
					done      <= 1'b1;
					reused    <= 1'b1;
					distance  <= dist_q;
					dropped   <= 1'b0;
					bin_count <= '0;
					state_q   <= ST_IDLE;
				end
				ST_MISS: begin
					if (eu_q != FULL_EU) begin
						eu_q <= eu_q + 1'b1;
					end
					done        <= 1'b1;
					reused      <= 1'b0;
					distance    <= '0;
					dropped     <= (eu_q == FULL_EU);
					bin_count   <= '0;
					reuse_total <= reuse_q;
					state_q     <= ST_IDLE;
				end
				ST_READ: begin
					done        <= 1'b1;
					reused      <= 1'b0;
					distance    <= '0;
					dropped     <= 1'b0;
					bin_count   <= bin_ok_q ? h_rdata : '0;
					reuse_total <= reuse_q;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: bench/access_distance_histogram_test.sv
`timescale 1ns / 1ps
// access_distance_histogram_test: self-checking bench of the reuse distance profiler
// depends on adh_pkg and access_distance_histogram

module access_distance_histogram_test;
	import adh_pkg::*;

	localparam int ENTRIES = 1024;
	localparam int BINS    = 1024;
	localparam logic REQ_ACCESS = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	typedef struct {
		logic                 req_type;
		logic [TAG_W-1:0]     address;
		logic [BIN_IDX_W-1:0] bin_index;
	} txn_t;

	typedef struct {
		logic               reused;
		logic [DIST_W-1:0]  distance;
		logic               dropped;
		logic [BIN_W-1:0]   bin_count;
		logic [REUSE_W-1:0] reuse_total;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [OFF_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic req_type = 1'b0;
	logic [TAG_W-1:0] address = '0;
	logic [BIN_IDX_W-1:0] bin_index = '0;
	logic busy, done, reused, dropped;
	logic [DIST_W-1:0] distance;
	logic [BIN_W-1:0] bin_count;
	logic [REUSE_W-1:0] reuse_total;

	// profiler shadow state
	logic [OFF_W-1:0] shift_amt = OFFSET_RESET;
	logic [39:0] access_cnt = '0;
	logic [63:0] tracked_tag [ENTRIES];
	logic [39:0] tracked_seen [ENTRIES];
	int tracked_used = 0;
	logic [31:0] hist [BINS];
	logic [39:0] reuse_cnt = '0;

	txn_t pending[$];
	outcome_t expected_out[$];
	int errors = 0;
	bit taken = 0;
	int burst_left = 4;
	int gap_left = 0;

	always #5 clk = ~clk;

	access_distance_histogram u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.start(start), .busy(busy), .req_type(req_type), .address(address),
		.bin_index(bin_index), .done(done), .reused(reused), .distance(distance),
		.dropped(dropped), .bin_count(bin_count), .reuse_total(reuse_total)
	);

	initial begin
		for (int i = 0; i < BINS; i++)
			hist[i] = '0;
	end

	// work out the outcome of one transaction and update the shadow state
	function automatic outcome_t profile_txn(txn_t t);
		outcome_t o;
		logic [63:0] blk;
		logic [39:0] span;
		int bin;
		bit hit;
		o = '{1'b0, '0, 1'b0, '0, '0};
		hit = 0;
		if (t.req_type == REQ_READ) begin
			o.bin_count = hist[t.bin_index];
		end else begin
			blk = t.address >> shift_amt;
			access_cnt = access_cnt + 1;
			for (int i = 0; i < tracked_used && !hit; i++) begin
				if (tracked_tag[i] == blk) begin
					hit = 1;
					span = access_cnt - tracked_seen[i];
					bin = (span < BINS - 1) ? int'(span) : BINS - 1;
					if (hist[bin] != '1)
						hist[bin]++;
					if (reuse_cnt != '1)
						reuse_cnt++;
					tracked_seen[i] = access_cnt;
					o.reused = 1'b1;
					o.distance = (span < 1023) ? span[DIST_W-1:0] : 10'd1023;
				end
			end
			if (!hit) begin
				if (tracked_used < ENTRIES) begin
					tracked_tag[tracked_used] = blk;
					tracked_seen[tracked_used] = access_cnt;
					tracked_used++;
				end else begin
					o.dropped = 1'b1;
				end
			end
		end
		o.reuse_total = reuse_cnt;
		return o;
	endfunction

	// driver: bursts of transactions separated by random gaps
	always @(negedge clk) begin
		if (start && !taken) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending.size() > 0) begin
			txn_t t;
			t = pending.pop_front();
			req_type <= t.req_type;
			address <= t.address;
			bin_index <= t.bin_index;
			start <= 1'b1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 12);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: predict on acceptance, check each result strobe
	always @(posedge clk) begin
		taken = start && !busy && arst_n;
		if (taken)
			expected_out.push_back(profile_txn('{req_type, address, bin_index}));
		if (done) begin
			if (expected_out.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result at %0t", $time);
			end else begin
				outcome_t e;
				e = expected_out.pop_front();
				if (e.reused !== reused || e.distance !== distance ||
					e.dropped !== dropped || e.bin_count !== bin_count ||
					e.reuse_total !== reuse_total) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at %0t: exp %0b %0d %0b %0d %0d got %0b %0d %0b %0d %0d",
							$time, e.reused, e.distance, e.dropped, e.bin_count, e.reuse_total,
							reused, distance, dropped, bin_count, reuse_total);
				end
			end
		end
	end

	task automatic queue_access(logic [63:0] a);
		pending.push_back('{REQ_ACCESS, a, 10'($urandom)});
	endtask

	task automatic queue_read(logic [9:0] b);
		pending.push_back('{REQ_READ, {$urandom, $urandom}, b});
	endtask

	task automatic wait_idle();
		while (pending.size() > 0 || start || expected_out.size() > 0 || busy)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_offset(logic [OFF_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		shift_amt = v;
	endtask

	// random mix over a small pool of hot blocks, with some noise addresses
	task automatic queue_random(int n);
		logic [63:0] hot [16];
		for (int i = 0; i < 16; i++)
			hot[i] = {$urandom, $urandom};
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: queue_read(($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 40))
					: 10'($urandom));
				2: queue_access({$urandom, $urandom});
				default: queue_access(hot[$urandom_range(0, 15)] ^ 64'($urandom_range(0, 8191)));
			endcase
		end
	endtask

	// stimulus phases
	initial begin
		logic [3:0] offsets [6] = '{4'd0, 4'd12, 4'd15, 4'd13, 4'd3, 4'd6};
		int fill_n;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reuse, extremes, reads of edge bins
		queue_access(64'h0);
		queue_access(64'h3f);
		queue_access(64'hffff_ffff_ffff_ffff);
		queue_access(64'h40);
		queue_access(64'h0);
		queue_access(64'hffff_ffff_ffff_ffc0);
		queue_read(10'd0);
		queue_read(10'd1);
		queue_read(10'd2);
		queue_read(10'd3);
		queue_read(10'd1023);
		queue_read(10'h2aa);
		queue_read(10'h155);

		foreach (offsets[k]) begin
			write_offset(offsets[k]);
			queue_random(30);
		end

		// fill the rest of the table, then force drops and long distances
		write_offset(4'd0);
		fill_n = ENTRIES - tracked_used;
		for (int i = 0; i < fill_n; i++)
			queue_access(64'ha500_0000_0000_0000 + 64'(i));
		wait_idle();
		for (int i = 0; i < 8; i++)
			queue_access({$urandom, $urandom});
		queue_access(64'ha500_0000_0000_0005);
		queue_access(64'h0);
		queue_access(64'ha500_0000_0000_0005);
		queue_read(10'd1023);
		queue_read(10'd2);
		queue_random(30);

		wait_idle();
		repeat (30) @(posedge clk);
		if (errors == 0 && expected_out.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: access_distance_histogram.f
hdl/adh_pkg.sv
hdl/adh_ram.sv
hdl/adh_match.sv
hdl/access_distance_histogram.sv
bench/access_distance_histogram_test.sv
